### hdl/ncfl_pkg.sv
// Package for the near-cube factor layout core.
// Holds the width constants, the sequencer state type and the layout choice codes.
// Depends on nothing.
package ncfl_pkg;

   // Field widths of the item and result transactions.
   localparam int COUNT_BITS = 20;
   localparam int GROUP_BITS = 12;

   // Ceiling square root of a COUNT_BITS value fits in ROOT_BITS bits; so does the cube root.
   localparam int ROOT_BITS = (COUNT_BITS + 1) / 2 + 1;
   localparam int REM_BITS = ROOT_BITS + 1;
   localparam int POW_BITS = COUNT_BITS + 2;
   localparam int MUL_B_BITS = (GROUP_BITS > ROOT_BITS) ? GROUP_BITS : ROOT_BITS;
   localparam int PROD_BITS = COUNT_BITS + MUL_B_BITS;
   localparam int SUM_BITS = PROD_BITS + 1;
   localparam int BITCNT_BITS = $clog2(COUNT_BITS);

   // Result field widths.
   localparam int WIDTH_BITS = 32;
   localparam int HEIGHT_BITS = COUNT_BITS;
   localparam int LARGE_BITS = COUNT_BITS;
   localparam int SMALL_BITS = ROOT_BITS;
   localparam int CUBE_BITS = 7;
   localparam int CHOICE_BITS = 2;

   // Layout choice codes.
   localparam logic [CHOICE_BITS-1:0] CHOICE_LARGE = 2'd0;
   localparam logic [CHOICE_BITS-1:0] CHOICE_SMALL = 2'd1;
   localparam logic [CHOICE_BITS-1:0] CHOICE_CUBE = 2'd2;

   // Multiplier schedule, one product per step.
   localparam logic [2:0] MUL_A_S = 3'd0;
   localparam logic [2:0] MUL_B_C = 3'd1;
   localparam logic [2:0] MUL_B_S = 3'd2;
   localparam logic [2:0] MUL_A_C = 3'd3;
   localparam logic [2:0] MUL_C_S = 3'd4;
   localparam logic [2:0] MUL_A_B = 3'd5;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CUBE   = 8'b0000_0010,
      ST_DSTART = 8'b0000_0100,
      ST_DIV    = 8'b0000_1000,
      ST_CHECK  = 8'b0001_0000,
      ST_SQRT   = 8'b0010_0000,
      ST_MUL    = 8'b0100_0000,
      ST_PICK   = 8'b1000_0000
   } state_type;

endpackage

### hdl/near_cube_factor_layout_core.sv
// Near-cube factor layout core: sequencer with a shared restoring divider and multiplier.
// Depends on ncfl_pkg.
//
// Usage:
//   req channel (req_valid/req_ready) carries one transaction: item_count N and group_size S.
//   rsp channel (rsp_valid/rsp_ready) returns one transaction per request: the chosen
//   layout_width/layout_height, the factors a, b, c and the layout_choice code.
//   A count of zero is handled as a count of one.
// Flow:
//   One request at a time; req_ready is low from acceptance until the result is loaded
//   and rises the cycle after. The divisor searches dominate the run time: every
//   trial runs the shared restoring divider, one quotient bit per cycle, so N with
//   few small divisors takes longest.
// Reset: synchronous, active high; the sequencer returns to idle and rsp_valid drops.
// Stall: a finished result waits in the output register; a new request is accepted
//   while it waits, and the next result is held internally until rsp_ready frees the
//   output register.
module near_cube_factor_layout_core
   import ncfl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COUNT_BITS-1:0]  req_item_count,
   input  logic [GROUP_BITS-1:0]  req_group_size,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WIDTH_BITS-1:0]  rsp_layout_width,
   output logic [HEIGHT_BITS-1:0] rsp_layout_height,
   output logic [LARGE_BITS-1:0]  rsp_factor_large,
   output logic [SMALL_BITS-1:0]  rsp_factor_small,
   output logic [CUBE_BITS-1:0]   rsp_factor_cube,
   output logic [CHOICE_BITS-1:0] rsp_layout_choice
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  n_ff, n_in;
   logic [GROUP_BITS-1:0]  s_ff, s_in;
   logic [COUNT_BITS-1:0]  m_ff, m_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [POW_BITS-1:0]    sq_ff, sq_in;
   logic [POW_BITS-1:0]    cube_ff, cube_in;
   logic                   stage_ff, stage_in;
   logic [ROOT_BITS-1:0]   d_ff, d_in;
   logic [COUNT_BITS-1:0]  dq_ff, dq_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [BITCNT_BITS-1:0] bit_ff, bit_in;
   logic [ROOT_BITS-1:0]   c_ff, c_in;
   logic [COUNT_BITS-1:0]  a_ff, a_in;
   logic [ROOT_BITS-1:0]   b_ff, b_in;
   logic [2:0]             step_ff, step_in;
   logic [WIDTH_BITS-1:0]  w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [HEIGHT_BITS-1:0] h0_ff, h0_in, h1_ff, h1_in, h2_ff, h2_in;
   logic [SUM_BITS-1:0]    best_ff, best_in;
   logic [CHOICE_BITS-1:0] pick_ff, pick_in;
   logic                   done_ff, done_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [LARGE_BITS-1:0]  large_ff, large_in;
   logic [SMALL_BITS-1:0]  small_ff, small_in;
   logic [CUBE_BITS-1:0]   cubef_ff, cubef_in;
   logic [CHOICE_BITS-1:0] choice_ff, choice_in;

   // Shared datapath signals.
   logic [COUNT_BITS-1:0]  div_target;
   logic [REM_BITS-1:0]    rem_shift;
   logic                   rem_ge;
   logic                   found;
   logic [COUNT_BITS-1:0]  found_quo;
   logic [COUNT_BITS-1:0]  mul_a;
   logic [MUL_B_BITS-1:0]  mul_b;
   logic [PROD_BITS-1:0]   prod;
   logic [SUM_BITS-1:0]    cand_sum;
   logic                   load_out;

   assign req_ready = (state_ff == ST_IDLE) && !done_ff;

   // Dividend follows the search stage: N for c, N/c for b0.
   assign div_target = stage_ff ? m_ff : n_ff;

   // One restoring division step.
   assign rem_shift = {rem_ff[REM_BITS-2:0], dq_ff[COUNT_BITS-1]};
   assign rem_ge = (rem_shift >= {1'b0, d_ff});

   // A divisor is found when it is one, or after a division with zero remainder.
   always_comb begin
      found = 1'b0;
      found_quo = dq_ff;
      if (state_ff == ST_DSTART && d_ff == ROOT_BITS'(1)) begin
         found = 1'b1;
         found_quo = div_target;
      end else if (state_ff == ST_CHECK && rem_ff == '0) begin
         found = 1'b1;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff)
         MUL_A_S: begin
            mul_a = a_ff;
            mul_b = MUL_B_BITS'(s_ff);
         end
         MUL_B_C: begin
            mul_a = COUNT_BITS'(b_ff);
            mul_b = MUL_B_BITS'(c_ff);
         end
         MUL_B_S: begin
            mul_a = COUNT_BITS'(b_ff);
            mul_b = MUL_B_BITS'(s_ff);
         end
         MUL_A_C: begin
            mul_a = a_ff;
            mul_b = MUL_B_BITS'(c_ff);
         end
         MUL_C_S: begin
            mul_a = COUNT_BITS'(c_ff);
            mul_b = MUL_B_BITS'(s_ff);
         end
         MUL_A_B: begin
            mul_a = a_ff;
            mul_b = MUL_B_BITS'(b_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   // Candidate sum for the compare pass.
   always_comb begin
      case (step_ff)
         3'd0:    cand_sum = SUM_BITS'(w0_ff) + SUM_BITS'(h0_ff);
         3'd1:    cand_sum = SUM_BITS'(w1_ff) + SUM_BITS'(h1_ff);
         default: cand_sum = SUM_BITS'(w2_ff) + SUM_BITS'(h2_ff);
      endcase
   end

   // The finished result moves to the output register once it is free.
   assign load_out = done_ff && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      s_in = s_ff;
      m_in = m_ff;
      root_in = root_ff;
      sq_in = sq_ff;
      cube_in = cube_ff;
      stage_in = stage_ff;
      d_in = d_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      c_in = c_ff;
      a_in = a_ff;
      b_in = b_ff;
      step_in = step_ff;
      w0_in = w0_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      best_in = best_ff;
      pick_in = pick_ff;
      done_in = done_ff;
      if (load_out) begin
         done_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               n_in = (req_item_count == '0) ? COUNT_BITS'(1) : req_item_count;
               s_in = req_group_size;
               root_in = ROOT_BITS'(1);
               sq_in = POW_BITS'(1);
               cube_in = POW_BITS'(1);
               stage_in = 1'b0;
               state_in = ST_CUBE;
            end
         end
         ST_CUBE: begin
            // Count r up while r^3 < N, keeping r^2 and r^3 by differences.
            if (cube_ff < POW_BITS'(n_ff)) begin
               cube_in = cube_ff + (sq_ff << 1) + sq_ff + (POW_BITS'(root_ff) << 1)
                         + POW_BITS'(root_ff) + POW_BITS'(1);
               sq_in = sq_ff + (POW_BITS'(root_ff) << 1) + POW_BITS'(1);
               root_in = root_ff + ROOT_BITS'(1);
            end else begin
               d_in = root_ff;
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            if (!found) begin
               dq_in = div_target;
               rem_in = '0;
               bit_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? (rem_shift - {1'b0, d_ff}) : rem_shift;
            dq_in = {dq_ff[COUNT_BITS-2:0], rem_ge};
            bit_in = bit_ff + BITCNT_BITS'(1);
            if (bit_ff == BITCNT_BITS'(COUNT_BITS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!found) begin
               d_in = d_ff - ROOT_BITS'(1);
               state_in = ST_DSTART;
            end
         end
         ST_SQRT: begin
            // Count r up while r^2 < N/c.
            if (sq_ff < POW_BITS'(m_ff)) begin
               sq_in = sq_ff + (POW_BITS'(root_ff) << 1) + POW_BITS'(1);
               root_in = root_ff + ROOT_BITS'(1);
            end else begin
               d_in = root_ff;
               stage_in = 1'b1;
               state_in = ST_DSTART;
            end
         end
         ST_MUL: begin
            case (step_ff)
               MUL_A_S: w0_in = WIDTH_BITS'(prod);
               MUL_B_C: h0_in = HEIGHT_BITS'(prod);
               MUL_B_S: w1_in = WIDTH_BITS'(prod);
               MUL_A_C: h1_in = HEIGHT_BITS'(prod);
               MUL_C_S: w2_in = WIDTH_BITS'(prod);
               default: h2_in = HEIGHT_BITS'(prod);
            endcase
            if (step_ff == MUL_A_B) begin
               step_in = '0;
               state_in = ST_PICK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_PICK: begin
            // Strict compare so that a tie keeps the earlier candidate.
            if (step_ff == 3'd0 || cand_sum < best_ff) begin
               best_in = cand_sum;
               pick_in = CHOICE_BITS'(step_ff);
            end
            if (step_ff == 3'd2) begin
               done_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take the found divisor and its cofactor.
      if (found) begin
         if (!stage_ff) begin
            c_in = d_ff;
            m_in = found_quo;
            root_in = ROOT_BITS'(1);
            sq_in = POW_BITS'(1);
            state_in = ST_SQRT;
         end else begin
            if (found_quo > COUNT_BITS'(d_ff)) begin
               a_in = found_quo;
               b_in = d_ff;
            end else begin
               a_in = COUNT_BITS'(d_ff);
               b_in = ROOT_BITS'(found_quo);
            end
            step_in = '0;
            state_in = ST_MUL;
         end
      end
   end

   // Output register and its handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      width_in = width_ff;
      height_in = height_ff;
      large_in = large_ff;
      small_in = small_ff;
      cubef_in = cubef_ff;
      choice_in = choice_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         case (pick_ff)
            CHOICE_LARGE: begin
               width_in = w0_ff;
               height_in = h0_ff;
            end
            CHOICE_SMALL: begin
               width_in = w1_ff;
               height_in = h1_ff;
            end
            default: begin
               width_in = w2_ff;
               height_in = h2_ff;
            end
         endcase
         large_in = a_ff;
         small_in = b_ff;
         cubef_in = CUBE_BITS'(c_ff);
         choice_in = pick_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      s_ff <= s_in;
      m_ff <= m_in;
      root_ff <= root_in;
      sq_ff <= sq_in;
      cube_ff <= cube_in;
      stage_ff <= stage_in;
      d_ff <= d_in;
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      c_ff <= c_in;
      a_ff <= a_in;
      b_ff <= b_in;
      step_ff <= step_in;
      w0_ff <= w0_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      width_ff <= width_in;
      height_ff <= height_in;
      large_ff <= large_in;
      small_ff <= small_in;
      cubef_ff <= cubef_in;
      choice_ff <= choice_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_layout_width = width_ff;
   assign rsp_layout_height = height_ff;
   assign rsp_factor_large = large_ff;
   assign rsp_factor_small = small_ff;
   assign rsp_factor_cube = cubef_ff;
   assign rsp_layout_choice = choice_ff;

endmodule

### tb/near_cube_factor_layout_checker.sv
// Checker for the near-cube factor layout core: watches both channels, predicts each layout
// and compares every result transaction field by field against the oldest prediction.
// Depends on ncfl_pkg for the field widths and the layout choice codes.
module near_cube_factor_layout_checker
   import ncfl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [COUNT_BITS-1:0]  req_item_count,
   input  logic [GROUP_BITS-1:0]  req_group_size,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [WIDTH_BITS-1:0]  rsp_layout_width,
   input  logic [HEIGHT_BITS-1:0] rsp_layout_height,
   input  logic [LARGE_BITS-1:0]  rsp_factor_large,
   input  logic [SMALL_BITS-1:0]  rsp_factor_small,
   input  logic [CUBE_BITS-1:0]   rsp_factor_cube,
   input  logic [CHOICE_BITS-1:0] rsp_layout_choice,
   output int                     mismatch_count,
   output int                     layouts_pending,
   output int                     layouts_checked,
   output logic [2:0]             choices_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [LARGE_BITS-1:0]  large_factor;
      logic [SMALL_BITS-1:0]  small_factor;
      logic [CUBE_BITS-1:0]   cube;
      logic [CHOICE_BITS-1:0] choice;
   } layout_type;

   layout_type expected_layouts [$];
   layout_type oldest_layout;

   // Splits the count into near-cube factors and picks the layout with the smallest
   // width plus height; ties go to the earlier candidate.
   function automatic layout_type predict_layout(input logic [COUNT_BITS-1:0] count,
                                                 input logic [GROUP_BITS-1:0] group);
      longint unsigned n, s, root, c, m, b0, q, a, b;
      longint unsigned wide [3];
      longint unsigned high [3];
      longint unsigned span [3];
      logic [CHOICE_BITS-1:0] pick;
      int idx;
      layout_type layout;
      n = count;
      s = group;
      // A zero count lays out like a single item.
      if (n == 0) n = 1;
      root = 1;
      while (root * root * root < n) root++;
      c = root;
      while (c > 1 && n % c != 0) c--;
      m = n / c;
      root = 1;
      while (root * root < m) root++;
      b0 = root;
      while (b0 > 1 && m % b0 != 0) b0--;
      q = m / b0;
      a = (q > b0) ? q : b0;
      b = (q < b0) ? q : b0;
      wide[0] = a * s;
      high[0] = b * c;
      wide[1] = b * s;
      high[1] = a * c;
      wide[2] = c * s;
      high[2] = a * b;
      for (idx = 0; idx < 3; idx++) span[idx] = wide[idx] + high[idx];
      if (span[0] <= span[1] && span[0] <= span[2]) begin
         pick = CHOICE_LARGE;
         idx = 0;
      end else if (span[1] <= span[2]) begin
         pick = CHOICE_SMALL;
         idx = 1;
      end else begin
         pick = CHOICE_CUBE;
         idx = 2;
      end
      layout.width = WIDTH_BITS'(wide[idx]);
      layout.height = HEIGHT_BITS'(high[idx]);
      layout.large_factor = LARGE_BITS'(a);
      layout.small_factor = SMALL_BITS'(b);
      layout.cube = CUBE_BITS'(c);
      layout.choice = pick;
      return layout;
   endfunction

   task automatic check_field(input string field, input longint unsigned expected,
                              input longint unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         mismatch_count++;
      end
   endtask

   // Request transactions queue a prediction; result transactions retire the oldest one.
   always @(posedge clock) begin
      if (reset) begin
         expected_layouts.delete();
         mismatch_count = 0;
         layouts_pending = 0;
         layouts_checked = 0;
         choices_seen = '0;
      end else begin
         if (req_valid && req_ready)
            expected_layouts.push_back(predict_layout(req_item_count, req_group_size));
         if (rsp_valid && rsp_ready) begin
            if (expected_layouts.size() == 0) begin
               $error("Layout result with no request waiting: width %0d, height %0d",
                      rsp_layout_width, rsp_layout_height);
               mismatch_count++;
            end else begin
               oldest_layout = expected_layouts.pop_front();
               check_field("layout_width", oldest_layout.width, rsp_layout_width);
               check_field("layout_height", oldest_layout.height, rsp_layout_height);
               check_field("factor_large", oldest_layout.large_factor, rsp_factor_large);
               check_field("factor_small", oldest_layout.small_factor, rsp_factor_small);
               check_field("factor_cube", oldest_layout.cube, rsp_factor_cube);
               check_field("layout_choice", oldest_layout.choice, rsp_layout_choice);
               if (rsp_layout_choice <= CHOICE_CUBE) choices_seen[rsp_layout_choice] = 1'b1;
               layouts_checked++;
            end
         end
         layouts_pending = expected_layouts.size();
      end
   end

endmodule

### tb/tb_near_cube_factor_layout_core.sv
// Testbench top for the near-cube factor layout core: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ncfl_pkg, near_cube_factor_layout_core and near_cube_factor_layout_checker.
module tb_near_cube_factor_layout_core
   import ncfl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 6;
   localparam int DIRECTED_ITEMS = 23;
   localparam int RANDOM_ITEMS = 267;
   localparam int QUIET_ITEMS = 40;
   localparam int PRESSURE_AT = 60;
   localparam int HOLD_OFF_CYCLES = 30000;
   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COUNT_BITS-1:0]  req_item_count = '0;
   logic [GROUP_BITS-1:0]  req_group_size = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [WIDTH_BITS-1:0]  rsp_layout_width;
   logic [HEIGHT_BITS-1:0] rsp_layout_height;
   logic [LARGE_BITS-1:0]  rsp_factor_large;
   logic [SMALL_BITS-1:0]  rsp_factor_small;
   logic [CUBE_BITS-1:0]   rsp_factor_cube;
   logic [CHOICE_BITS-1:0] rsp_layout_choice;

   int         mismatch_count;
   int         layouts_pending;
   int         layouts_checked;
   logic [2:0] choices_seen;

   int   items_sent = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   logic quiet_tail = 1'b0;
   logic hold_off = 1'b0;

   // Corner cases: zero count and group, all-tie single item, perfect cubes around the
   // cube factor limit, a perfect square, the largest count, large primes, a power of two.
   int unsigned directed_count [DIRECTED_ITEMS] = '{
      0, 1, 0, 5, 2, 8, 27, 64, 1000, 1000000, 970299, 1030301, 1046529,
      1048575, 1048573, 997, 997, 4096, 3600, 720720, 524288, 999983, 1048575};
   int unsigned directed_group [DIRECTED_ITEMS] = '{
      5, 1, 0, 0, 4095, 3, 4095, 1, 7, 1, 4095, 2, 100,
      4095, 1, 500, 1, 2048, 64, 13, 1, 3000, 0};

   near_cube_factor_layout_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_item_count    (req_item_count),
      .req_group_size    (req_group_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_layout_width  (rsp_layout_width),
      .rsp_layout_height (rsp_layout_height),
      .rsp_factor_large  (rsp_factor_large),
      .rsp_factor_small  (rsp_factor_small),
      .rsp_factor_cube   (rsp_factor_cube),
      .rsp_layout_choice (rsp_layout_choice)
   );

   near_cube_factor_layout_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_item_count    (req_item_count),
      .req_group_size    (req_group_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_layout_width  (rsp_layout_width),
      .rsp_layout_height (rsp_layout_height),
      .rsp_factor_large  (rsp_factor_large),
      .rsp_factor_small  (rsp_factor_small),
      .rsp_factor_cube   (rsp_factor_cube),
      .rsp_layout_choice (rsp_layout_choice),
      .mismatch_count    (mismatch_count),
      .layouts_pending   (layouts_pending),
      .layouts_checked   (layouts_checked),
      .choices_seen      (choices_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Counts mostly stay small or smooth, since the divisor search makes counts with
   // few small divisors slow; a few span the whole field.
   function automatic logic [COUNT_BITS-1:0] random_count();
      int unsigned kind, product, factor;
      kind = $urandom_range(0, 99);
      if (kind < 50) return COUNT_BITS'($urandom_range(0, 4095));
      if (kind < 80) begin
         product = 1;
         repeat ($urandom_range(1, 14)) begin
            case ($urandom_range(0, 5))
               0: factor = 2;
               1: factor = 3;
               2: factor = 5;
               3: factor = 7;
               4: factor = 11;
               default: factor = 13;
            endcase
            if (product * factor < (1 << COUNT_BITS)) product = product * factor;
         end
         return COUNT_BITS'(product);
      end
      if (kind < 94) return COUNT_BITS'($urandom_range(0, 65535));
      return COUNT_BITS'($urandom_range(0, (1 << COUNT_BITS) - 1));
   endfunction

   function automatic logic [GROUP_BITS-1:0] random_group();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return GROUP_BITS'(1);
         default: return GROUP_BITS'($urandom_range(0, (1 << GROUP_BITS) - 1));
      endcase
   endfunction

   // Offers one request transaction and holds it until accepted, then maybe idles.
   task automatic deliver_request(input logic [COUNT_BITS-1:0] count,
                                  input logic [GROUP_BITS-1:0] group);
      int gap;
      req_valid <= 1'b1;
      req_item_count <= count;
      req_group_size <= group;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (items_sent == DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_ITEMS) quiet_tail <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Request stimulus and the final verdict.
   initial begin
      int idx;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < DIRECTED_ITEMS; idx++)
         deliver_request(COUNT_BITS'(directed_count[idx]), GROUP_BITS'(directed_group[idx]));
      for (idx = 0; idx < RANDOM_ITEMS; idx++)
         deliver_request(random_count(), random_group());
      req_valid <= 1'b0;
      @(posedge clock);
      wait (layouts_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d request transactions (%0d directed corner cases) and %0d checked",
               items_sent, DIRECTED_ITEMS, layouts_checked);
      $display("layouts; choices seen (cube, small, large) = %b, %0d-cycle hold-off.",
               choices_seen, HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("near_cube_factor_layout_core test passed");
      end else begin
         $display("near_cube_factor_layout_core test failed");
      end
      $finish;
   end

   // Result back-pressure: random stall bursts and the long hold-off, quiet in the tail of the run.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One long receiver hold-off so the core fills up and stalls its request channel.
   initial begin
      wait (items_sent >= PRESSURE_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog on cycles without any accepted transaction.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("near_cube_factor_layout_core test failed");
            $finish;
         end
      end
   end

endmodule

### near_cube_factor_layout_core.f
hdl/ncfl_pkg.sv
hdl/near_cube_factor_layout_core.sv
tb/near_cube_factor_layout_checker.sv
tb/tb_near_cube_factor_layout_core.sv
